### rtl/core/mcpf_pkg.sv
// Shared constants, codes and types of the multi-channel pipe FIFO.
package mcpf_pkg;

	localparam int NUM_PIPES         = 256;
	localparam int BUFFER_DEPTH      = 512;
	localparam int FIRST_ALLOCATABLE = 3;

	localparam int PIPE_W = $clog2(NUM_PIPES);
	localparam int PTR_W  = $clog2(BUFFER_DEPTH);
	localparam int ADDR_W = $clog2(NUM_PIPES * BUFFER_DEPTH);

	// Create scans only the pipes that an 8-bit pipe_id can address.
	localparam int SCAN_LIM   = (NUM_PIPES < 256) ? NUM_PIPES : 256;
	localparam int CHUNK_W    = 16;
	localparam int CHUNK_IW   = $clog2(CHUNK_W);
	localparam int NUM_CHUNKS = (SCAN_LIM + CHUNK_W - 1) / CHUNK_W;
	localparam int CHUNK_CW   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
	localparam int NUM_ROWS   = 1 << CHUNK_CW;

	typedef enum logic [1:0] {
		ACT_CREATE = 2'd0,
		ACT_CLOSE  = 2'd1,
		ACT_WRITE  = 2'd2,
		ACT_READ   = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_INVALID = 3'd1,
		STAT_NOFREE  = 3'd2,
		STAT_FULL    = 3'd3,
		STAT_EMPTY   = 3'd4
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC,
		ST_LOAD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
	} scan_req_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [PIPE_W-1:0] idx;
	} scan_rsp_t;

endpackage

### rtl/core/mcpf_if.sv
// Word channels of the multi-channel pipe FIFO: command in, response out.
interface mcpf_cmd_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [7:0]        pipe_id;
	logic signed [7:0] data_byte;

	modport source (output valid, action, pipe_id, data_byte, input ready);
	modport sink   (input valid, action, pipe_id, data_byte, output ready);
endinterface

interface mcpf_rsp_if;
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [7:0]        pipe_out;
	logic signed [7:0] data_out;

	modport source (output valid, status, pipe_out, data_out, input ready);
	modport sink   (input valid, status, pipe_out, data_out, output ready);
endinterface

### rtl/core/multi_channel_pipe_fifo_top.sv
// Top level of the multi-channel pipe FIFO: sequencer, pointer and byte memories.
//
// Usage: a table of byte pipes, each a ring buffer of BUFFER_DEPTH bytes that
// holds up to BUFFER_DEPTH-1 bytes. Send one command word on cmd (action,
// pipe_id, data_byte); exactly one response word (status, pipe_out, data_out)
// comes back on rsp for every command, in order. Both channels move a word at
// a rising edge with valid and ready high.
// Flow: the accept edge latches the command and reads both pointers of its pipe.
// Close and write then form the result in the execute state; read adds a
// byte read and a load state (pointer read, byte read, result); create runs
// the free-pipe scan, which covers one row of 16 pipes per cycle (16 rows at
// 256 pipes) and stops at the first row that holds a free pipe. cmd.ready is
// high only while the sequencer is idle and returns once the result has moved
// to the output register; the one pointer advance/compare unit and the single
// port of each memory carry one command at a time.
// Reset: asynchronous, arst_n low. Pipe 0 is in use, all others free, every
// pointer reads zero; no clearing pass runs, the block is ready at once. Byte
// storage is not cleared; the pointers never let an unwritten byte be read.
// Stall: the response sits in an output register. The next command is still
// accepted while it waits; the sequencer holds its finished result until the
// output register frees.
module multi_channel_pipe_fifo_top (
	input logic        clk,
	input logic        arst_n,
	mcpf_cmd_if.sink   cmd,
	mcpf_rsp_if.source rsp
);
	import mcpf_pkg::*;

	// Sequencer
	state_t state_q, state_d;

	// Latched command
	act_t              act_q;
	logic [PIPE_W-1:0] pidx_q;
	logic [7:0]        id_q;
	logic              id_ok_q;
	logic [7:0]        byte_q;

	// Pipe table: in-use flags and pointer-valid flags in flops
	logic [NUM_PIPES-1:0] in_use_q;
	logic [NUM_PIPES-1:0] ptr_vld_q;

	// Pointer memories, one entry per pipe
	logic [PTR_W-1:0] rp_mem [NUM_PIPES];
	logic [PTR_W-1:0] wp_mem [NUM_PIPES];
	logic [PTR_W-1:0] rp_rd_q, wp_rd_q;

	// Byte storage
	logic [7:0] store_mem [NUM_PIPES * BUFFER_DEPTH];
	logic [7:0] store_rd_q;

	// Result staging and output register
	stat_t             res_status_q, res_status_d;
	logic [7:0]        res_pipe_q, res_pipe_d;
	logic [7:0]        res_data_q;
	logic              res_ld;
	logic              res_data_ld;
	logic              out_vld_q;
	stat_t             out_status_q;
	logic [7:0]        out_pipe_q;
	logic [7:0]        out_data_q;
	logic              out_load;

	// Free-pipe scanner
	scan_req_t scan_req;
	scan_rsp_t scan_rsp;

	// Shared pointer unit
	logic             pipe_ok;
	logic             is_wr;
	logic [PTR_W-1:0] rp_eff, wp_eff;
	logic [PTR_W-1:0] op_ptr, op_adv;
	logic             full, empty;
	logic [ADDR_W-1:0] store_addr;
	logic [PTR_W-1:0] rp_new, wp_new;

	// Table and memory controls
	logic              cmd_acc;
	logic              ptr_we;
	logic              store_we, store_re;
	logic              use_set, use_clr, vld_set, vld_clr;
	logic [PIPE_W-1:0] upd_idx;

	assign cmd_acc = cmd.valid && cmd.ready;

	mcpf_free_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (scan_req),
		.in_use (in_use_q),
		.rsp    (scan_rsp)
	);

	// Pointer advance with wrap and the full/empty compares.
	assign pipe_ok    = id_ok_q && in_use_q[pidx_q];
	assign is_wr      = (act_q == ACT_WRITE);
	assign rp_eff     = ptr_vld_q[pidx_q] ? rp_rd_q : '0;
	assign wp_eff     = ptr_vld_q[pidx_q] ? wp_rd_q : '0;
	assign op_ptr     = is_wr ? wp_eff : rp_eff;
	assign op_adv     = (op_ptr == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : op_ptr + 1'b1;
	assign full       = (op_adv == rp_eff);
	assign empty      = (rp_eff == wp_eff);
	assign rp_new     = is_wr ? rp_eff : op_adv;
	assign wp_new     = is_wr ? op_adv : wp_eff;
	assign store_addr = ADDR_W'(pidx_q) * ADDR_W'(BUFFER_DEPTH) + ADDR_W'(op_ptr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.ready    = 1'b0;
		scan_req     = '0;
		res_ld       = 1'b0;
		res_data_ld  = 1'b0;
		res_status_d = STAT_OK;
		res_pipe_d   = '0;
		ptr_we       = 1'b0;
		store_we     = 1'b0;
		store_re     = 1'b0;
		use_set      = 1'b0;
		use_clr      = 1'b0;
		vld_set      = 1'b0;
		vld_clr      = 1'b0;
		upd_idx      = pidx_q;
		out_load     = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					if (act_t'(cmd.action) == ACT_CREATE) begin
						scan_req.start = 1'b1;
						state_d        = ST_SCAN;
					end else begin
						state_d = ST_EXEC;
					end
				end
			end

			ST_SCAN: begin
				upd_idx = scan_rsp.idx;
				if (scan_rsp.done) begin
					res_ld = 1'b1;
					if (scan_rsp.found) begin
						use_set    = 1'b1;
						vld_clr    = 1'b1;
						res_pipe_d = 8'(scan_rsp.idx);
					end else begin
						res_status_d = STAT_NOFREE;
					end
					state_d = ST_DONE;
				end
			end

			ST_EXEC: begin
				res_ld  = 1'b1;
				state_d = ST_DONE;
				if (act_q == ACT_CLOSE) begin
					if (id_q == 8'd0 || !pipe_ok) begin
						res_status_d = STAT_INVALID;
					end else begin
						use_clr = 1'b1;
						vld_clr = 1'b1;
					end
				end else if (id_q == 8'd1 || id_q == 8'd2 || !pipe_ok) begin
					res_status_d = STAT_INVALID;
				end else if (is_wr) begin
					if (full) begin
						res_status_d = STAT_FULL;
					end else begin
						store_we = 1'b1;
						ptr_we   = 1'b1;
						vld_set  = 1'b1;
					end
				end else begin
					if (empty) begin
						res_status_d = STAT_EMPTY;
					end else begin
						store_re = 1'b1;
						ptr_we   = 1'b1;
						vld_set  = 1'b1;
						state_d  = ST_LOAD;
					end
				end
			end

			ST_LOAD: begin
				res_data_ld = 1'b1;
				state_d     = ST_DONE;
			end

			ST_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Latch the command and read both pointers of the addressed pipe.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			act_q   <= act_t'(cmd.action);
			id_q    <= cmd.pipe_id;
			pidx_q  <= PIPE_W'(cmd.pipe_id);
			id_ok_q <= ({24'd0, cmd.pipe_id} < 32'(NUM_PIPES));
			byte_q  <= cmd.data_byte;
			rp_rd_q <= rp_mem[PIPE_W'(cmd.pipe_id)];
			wp_rd_q <= wp_mem[PIPE_W'(cmd.pipe_id)];
		end
	end

	always_ff @(posedge clk) begin
		if (ptr_we) begin
			rp_mem[pidx_q] <= rp_new;
			wp_mem[pidx_q] <= wp_new;
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_addr] <= byte_q;
		end
		if (store_re) begin
			store_rd_q <= store_mem[store_addr];
		end
	end

	// Pipe table flags; a cleared pointer-valid flag makes both pointers read zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= NUM_PIPES'(1);
			ptr_vld_q <= '0;
		end else begin
			if (use_set) begin
				in_use_q[upd_idx] <= 1'b1;
			end else if (use_clr) begin
				in_use_q[upd_idx] <= 1'b0;
			end
			if (vld_set) begin
				ptr_vld_q[upd_idx] <= 1'b1;
			end else if (vld_clr) begin
				ptr_vld_q[upd_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_pipe_q   <= res_pipe_d;
			res_data_q   <= '0;
		end else if (res_data_ld) begin
			res_data_q <= store_rd_q;
		end
	end

	// Output register: hold the word until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_pipe_q   <= res_pipe_q;
			out_data_q   <= res_data_q;
		end
	end

	assign rsp.valid    = out_vld_q;
	assign rsp.status   = out_status_q;
	assign rsp.pipe_out = out_pipe_q;
	assign rsp.data_out = out_data_q;

`ifndef NO_ASSERTIONS
	a_pipe0_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		in_use_q[0])
		else $error("pipe 0 lost its in-use flag");

	a_ptr_only_live: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_vld_q & ~in_use_q) == '0)
		else $error("pointers kept for a pipe that is not in use");

	a_scan_free: assert property (@(posedge clk) disable iff (!arst_n)
		scan_rsp.found |-> !in_use_q[scan_rsp.idx] &&
			32'(scan_rsp.idx) >= FIRST_ALLOCATABLE)
		else $error("scan picked a pipe that is not free");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> !cmd.ready)
		else $error("command taken while the previous one is in work");
`endif

endmodule

### rtl/core/mcpf_free_scan.sv
// Iterative lowest-free-pipe search, one row of pipes per cycle.
module mcpf_free_scan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mcpf_pkg::scan_req_t                 req,
	input  logic [mcpf_pkg::NUM_PIPES-1:0]      in_use,
	output mcpf_pkg::scan_rsp_t                 rsp
);
	import mcpf_pkg::*;

	logic [NUM_ROWS-1:0][CHUNK_W-1:0] free_rows;
	logic                             busy_q;
	logic [CHUNK_CW-1:0]              chunk_q;
	logic [CHUNK_W-1:0]               row;
	logic                             hit;
	logic [CHUNK_IW-1:0]              enc;
	logic                             last;

	// Mark free pipes; reserved and unaddressable slots never count as free.
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		for (genvar k = 0; k < CHUNK_W; k++) begin : g_bit
			if ((r * CHUNK_W + k) >= FIRST_ALLOCATABLE &&
			    (r * CHUNK_W + k) < SCAN_LIM) begin : g_live
				assign free_rows[r][k] = ~in_use[r * CHUNK_W + k];
			end else begin : g_dead
				assign free_rows[r][k] = 1'b0;
			end
		end
	end

	assign row  = free_rows[chunk_q];
	assign last = (chunk_q == CHUNK_CW'(NUM_CHUNKS - 1));

	// Priority encode, lowest index wins.
	always_comb begin
		hit = 1'b0;
		enc = '0;
		for (int k = CHUNK_W - 1; k >= 0; k--) begin
			if (row[k]) begin
				hit = 1'b1;
				enc = CHUNK_IW'(k);
			end
		end
	end

	assign rsp.done  = busy_q && (hit || last);
	assign rsp.found = busy_q && hit;
	assign rsp.idx   = PIPE_W'({chunk_q, enc});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			chunk_q <= '0;
		end else if (req.start) begin
			busy_q  <= 1'b1;
			chunk_q <= '0;
		end else if (rsp.done) begin
			busy_q  <= 1'b0;
		end else if (busy_q) begin
			chunk_q <= chunk_q + 1'b1;
		end
	end

endmodule
